// File: src/assert_macros.svh
// Assertion helper macros shared by the flicker driver RTL.
// No dependencies; each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every cycle outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lffp_pkg.sv
// Shared types and constants for the LED flicker PWM driver.
// No dependencies.
`timescale 1ns / 1ps

package lffp_pkg;

  localparam int DATA_W = 8;

  localparam logic [7:0] TICKS_PER_PERIOD = 8'd254;
  localparam logic [7:0] PPL_RESET        = 8'd50;
  localparam logic [7:0] RNG_SEED         = 8'd234;
  localparam logic [8:0] MAP_RESET        = 9'd256;
  localparam logic [8:0] MAP_SPLIT        = 9'd128;
  localparam logic [8:0] LEVEL_MIN        = 9'd5;
  localparam logic [8:0] LEVEL_MAX        = 9'd255;

  typedef struct packed {
    logic burst_active;
    logic led_lit;
  } result_t;

endpackage

// File: src/lffp_chaos.sv
// Intermittent-chaos brightness map with xorshift reseed.
// Depends on lffp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lffp_chaos (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  output logic [7:0] level
);
  import lffp_pkg::*;

  logic [8:0]  map_value, map_next;
  logic [7:0]  rng_state, rng_next;
  logic [8:0]  diff;
  logic [7:0]  d;
  logic [13:0] xsq;
  logic [15:0] dsq;
  logic [8:0]  mapped;
  logic [11:0] r1, r2;
  logic [7:0]  rnd;

  always_comb begin
    xsq  = 14'(map_value[6:0]) * 14'(map_value[6:0]);
    diff = MAP_RESET - map_value;
    d    = diff[7:0];
    dsq  = 16'(d) * 16'(d);
    if (map_value < MAP_SPLIT) begin
      mapped = map_value + {2'b00, xsq[13:7]};
    end else begin
      mapped = map_value - dsq[15:7];
    end

    r1  = {4'b0000, rng_state} ^ {1'b0, rng_state, 3'b000};
    r2  = r1 ^ (r1 >> 4);
    rnd = r2[7:0] ^ {r2[6:0], 1'b0};

    if (mapped < LEVEL_MIN || mapped > LEVEL_MAX) begin
      map_next = {1'b0, rnd};
      rng_next = rnd;
    end else begin
      map_next = mapped;
      rng_next = rng_state;
    end
    level = map_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_value <= MAP_RESET;
      rng_state <= RNG_SEED;
    end else if (step) begin
      map_value <= map_next;
      rng_state <= rng_next;
    end
  end

  `ASSERT_NEXT(a_map_range, step, map_value <= LEVEL_MAX,
               "map value left the 8-bit range after a step")

endmodule

// File: src/lffp_pwm.sv
// Burst sequencing and PWM tick counting for the flicker driver.
// Depends on lffp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lffp_pwm (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic                mode,
  input  logic [7:0]          burst_levels,
  input  logic [7:0]          periods_per_level,
  input  logic [7:0]          level,
  output logic                step,
  output lffp_pkg::result_t   res
);
  import lffp_pkg::*;

  logic [7:0] current_level, current_level_next;
  logic [7:0] pwm_count, pwm_count_next;
  logic [7:0] period_count, period_count_next;
  logic [7:0] levels_left, levels_left_next;
  logic [7:0] pwm_use, pc_use;

  always_comb begin
    current_level_next = current_level;
    pwm_count_next     = pwm_count;
    period_count_next  = period_count;
    levels_left_next   = levels_left;
    pwm_use            = pwm_count;
    pc_use             = period_count;
    step               = 1'b0;
    res.led_lit        = 1'b1;
    res.burst_active   = 1'b0;

    if (go) begin
      if (mode) begin
        levels_left_next  = burst_levels;
        period_count_next = 8'd0;
        pwm_count_next    = 8'd1;
        res.burst_active  = (burst_levels != 8'd0);
      end else if (levels_left != 8'd0 || period_count != 8'd0) begin
        if (period_count == 8'd0) begin
          // new level from the map
          step               = 1'b1;
          current_level_next = level;
          levels_left_next   = levels_left - 8'd1;
          pc_use             = periods_per_level;
          pwm_use            = 8'd1;
        end
        res.led_lit      = (pwm_use < current_level_next);
        res.burst_active = 1'b1;
        if (pwm_use >= TICKS_PER_PERIOD) begin
          pwm_count_next    = 8'd1;
          period_count_next = pc_use - 8'd1;
        end else begin
          pwm_count_next    = pwm_use + 8'd1;
          period_count_next = pc_use;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= 8'd0;
      pwm_count     <= 8'd1;
      period_count  <= 8'd0;
      levels_left   <= 8'd0;
    end else begin
      current_level <= current_level_next;
      pwm_count     <= pwm_count_next;
      period_count  <= period_count_next;
      levels_left   <= levels_left_next;
    end
  end

  `ASSERT_ALWAYS(a_pwm_range, pwm_count != 8'd0 && pwm_count <= TICKS_PER_PERIOD,
                 "pwm count outside 1..254")
  `ASSERT_NEXT(a_level_load, step, period_count != 8'd0,
               "new level loaded with no periods to run")

endmodule

// File: src/led_flicker_fluctuation_pwm.sv
// Candle-flicker LED driver: takes one tick or start word per clock while the
// result port is not stalled, and returns one result word per input word. Each
// input passes an input register, then the map/PWM state update, then the result
// register. A new word is accepted every clock unless m_tready holds off a full
// result register. Depends on lffp_pkg, lffp_chaos, lffp_pwm.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_flicker_fluctuation_pwm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lffp_pkg::DATA_W-1:0] s_tdata,   // [7:0] burst_levels
  input  logic                        s_tuser,   // [0] mode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lffp_pkg::DATA_W-1:0] m_tdata,   // [0] led_lit, [1] burst_active
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data   // periods_per_level
);
  import lffp_pkg::*;

  logic       in_vld;
  logic       in_mode;
  logic [7:0] in_levels;
  logic       out_vld;
  result_t    out_res;
  result_t    res;
  logic [7:0] periods_per_level;
  logic [7:0] ppl_eff;
  logic       adv;
  logic       step;
  logic [7:0] level;

  assign adv       = in_vld && (!out_vld || m_tready);
  assign s_tready  = !in_vld || adv;
  assign cfg_ready = 1'b1;
  assign ppl_eff   = (periods_per_level == 8'd0) ? 8'd1 : periods_per_level;
  assign m_tvalid  = out_vld;
  assign m_tdata   = {6'b000000, out_res.burst_active, out_res.led_lit};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld            <= 1'b0;
      out_vld           <= 1'b0;
      periods_per_level <= PPL_RESET;
    end else begin
      if (s_tvalid && s_tready) begin
        in_vld <= 1'b1;
      end else if (adv) begin
        in_vld <= 1'b0;
      end
      if (adv) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        periods_per_level <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= s_tuser;
      in_levels <= s_tdata;
    end
    if (adv) begin
      out_res <= res;
    end
  end

  lffp_chaos u_chaos (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .level (level)
  );

  lffp_pwm u_pwm (
    .clk               (clk),
    .rst               (rst),
    .go                (adv),
    .mode              (in_mode),
    .burst_levels      (in_levels),
    .periods_per_level (ppl_eff),
    .level             (level),
    .step              (step),
    .res               (res)
  );

  `ASSERT_NEXT(a_in_hold, in_vld && !adv, in_vld, "buffered input word dropped")
  `ASSERT_NEXT(a_out_fill, adv, out_vld, "processed word did not reach result register")

endmodule
